[rtl/gqvg_pkg.sv]
// Shared types, constants and saturation helpers for the glyph quad vertex generator.
// No dependencies; the cfg, table, quad and top modules import this package.
`timescale 1ns / 1ps
package gqvg_pkg;

  localparam int GLYPH_COUNT_DEF = 128;
  localparam int CFG_AW          = 5;
  localparam int CFG_DW          = 32;

  localparam logic [2:0] REG_SCALE_X       = 3'd0;
  localparam logic [2:0] REG_SCALE_Y       = 3'd1;
  localparam logic [2:0] REG_ADVANCE_SCALE = 3'd2;
  localparam logic [2:0] REG_INV_ATLAS_W   = 3'd3;
  localparam logic [2:0] REG_INV_ATLAS_H   = 3'd4;

  localparam logic       OP_LOAD   = 1'b0;
  localparam logic       OP_RENDER = 1'b1;

  localparam logic [2:0] LAST_VERTEX_IDX = 3'd5;
  localparam logic [16:0] TEX_ONE = 17'd65536;

  typedef struct packed {
    logic [13:0]       adv;
    logic [7:0]        wd;
    logic [7:0]        rw;
    logic signed [7:0] lf;
    logic signed [7:0] tp;
    logic [15:0]       tex_u;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [23:0] scale_x;
    logic [23:0] scale_y;
    logic [23:0] advance_scale;
    logic [16:0] inv_atlas_width;
    logic [16:0] inv_atlas_height;
  } cfg_t;

  // Request held in the lookup stage, with the table entry already read.
  typedef struct packed {
    logic               valid;
    logic               render;
    logic               first;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    entry_t             entry;
  } lookup_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [39:0] max_v;
    logic signed [39:0] min_v;
    max_v = 40'sh007FFFFFFF;
    min_v = -40'sh0080000000;
    if (v > max_v) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < min_v) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic [16:0] sat_tex(input logic [25:0] v);
    if (v > 26'(TEX_ONE)) begin
      sat_tex = TEX_ONE;
    end else begin
      sat_tex = v[16:0];
    end
  endfunction

endpackage

[rtl/gqvg_in_if.sv]
// Input request channel: valid/ready handshake with glyph load and render fields.
// Standalone interface, no package dependency.
`timescale 1ns / 1ps
interface gqvg_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic               first_of_string;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic [6:0]         char_code;
  logic [13:0]        load_advance;
  logic [7:0]         load_width;
  logic [7:0]         load_rows;
  logic signed [7:0]  load_left;
  logic signed [7:0]  load_top;
  logic [15:0]        load_tex_u;

  modport source (
    output valid, opcode, first_of_string, start_x, start_y, char_code,
           load_advance, load_width, load_rows, load_left, load_top, load_tex_u,
    input  ready
  );
  modport sink (
    input  valid, opcode, first_of_string, start_x, start_y, char_code,
           load_advance, load_width, load_rows, load_left, load_top, load_tex_u,
    output ready
  );
endinterface

[rtl/gqvg_out_if.sv]
// Result channel: valid/ready handshake carrying one textured vertex per transfer.
// Standalone interface, no package dependency.
`timescale 1ns / 1ps
interface gqvg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic [16:0]        tex_s;
  logic [16:0]        tex_t;
  logic               last_vertex;

  modport source (
    output valid, vertex_x, vertex_y, tex_s, tex_t, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, vertex_x, vertex_y, tex_s, tex_t, last_vertex,
    output ready
  );
endinterface

[rtl/gqvg_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module gqvg_ram #(
  parameter int WIDTH = 62,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/gqvg_cfg.sv]
// APB-style configuration registers: scales and reciprocal atlas sizes.
// Depends on gqvg_pkg for register codes and cfg_t.
`timescale 1ns / 1ps
module gqvg_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gqvg_pkg::CFG_AW-1:0]  paddr,
  input  logic [gqvg_pkg::CFG_DW-1:0]  pwdata,
  output logic [gqvg_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output gqvg_pkg::cfg_t               cfg
);
  import gqvg_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_SCALE_X:       cfg_nxt.scale_x          = pwdata[23:0];
        REG_SCALE_Y:       cfg_nxt.scale_y          = pwdata[23:0];
        REG_ADVANCE_SCALE: cfg_nxt.advance_scale    = pwdata[23:0];
        REG_INV_ATLAS_W:   cfg_nxt.inv_atlas_width  = pwdata[16:0];
        REG_INV_ATLAS_H:   cfg_nxt.inv_atlas_height = pwdata[16:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_x          <= 24'd65536;
      cfg_r.scale_y          <= 24'd65536;
      cfg_r.advance_scale    <= 24'd1311;
      cfg_r.inv_atlas_width  <= 17'd65536;
      cfg_r.inv_atlas_height <= 17'd65536;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SCALE_X:       prdata = {8'd0, cfg_r.scale_x};
      REG_SCALE_Y:       prdata = {8'd0, cfg_r.scale_y};
      REG_ADVANCE_SCALE: prdata = {8'd0, cfg_r.advance_scale};
      REG_INV_ATLAS_W:   prdata = {15'd0, cfg_r.inv_atlas_width};
      REG_INV_ATLAS_H:   prdata = {15'd0, cfg_r.inv_atlas_height};
      default:           prdata = '0;
    endcase
  end

endmodule

[rtl/gqvg_table.sv]
// Glyph metrics table: RAM write on load requests, RAM read on render requests,
// and the lookup stage that holds the read entry. Depends on gqvg_pkg, gqvg_ram.
`timescale 1ns / 1ps
module gqvg_table #(
  parameter int GLYPH_COUNT = gqvg_pkg::GLYPH_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic               first_of_string,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic [6:0]         char_code,
  input  gqvg_pkg::entry_t   load_entry,
  input  logic               take,
  output gqvg_pkg::lookup_t  lkp
);
  import gqvg_pkg::*;

  localparam int IDX_W = $clog2(GLYPH_COUNT);

  logic                   acc;
  logic [7:0]             code8;
  logic                   in_range;
  logic [IDX_W-1:0]       idx;
  logic                   we;
  logic                   re;
  logic [ENTRY_W-1:0]     rdata;
  logic [GLYPH_COUNT-1:0] vld_r;
  logic [GLYPH_COUNT-1:0] vld_nxt;
  logic                   hit_r;
  logic                   v1_r;
  logic                   render_r;
  logic                   first_r;
  logic signed [31:0]     start_x_r;
  logic signed [31:0]     start_y_r;

  assign in_ready = !v1_r | take;
  assign acc      = in_valid & in_ready;
  assign code8    = {1'b0, char_code};
  assign in_range = 9'(code8) < 9'(GLYPH_COUNT);
  assign idx      = code8[IDX_W-1:0];
  assign we       = acc & (opcode == OP_LOAD) & in_range;
  assign re       = acc & (opcode == OP_RENDER);

  gqvg_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (GLYPH_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .re    (re),
    .addr  (idx),
    .wdata (load_entry),
    .rdata (rdata)
  );

  always_comb begin
    vld_nxt = vld_r;
    if (we) begin
      vld_nxt[idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      v1_r  <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (acc) begin
        v1_r <= 1'b1;
      end else if (take) begin
        v1_r <= 1'b0;
      end
      // never-written entries and codes past the table read as zero
      if (re) begin
        hit_r <= in_range & vld_r[idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      render_r  <= opcode == OP_RENDER;
      first_r   <= first_of_string;
      start_x_r <= start_x;
      start_y_r <= start_y;
    end
  end

  always_comb begin
    lkp.valid   = v1_r;
    lkp.render  = render_r;
    lkp.first   = first_r;
    lkp.start_x = start_x_r;
    lkp.start_y = start_y_r;
    lkp.entry   = hit_r ? entry_t'(rdata) : '0;
  end

endmodule

[rtl/gqvg_quad.sv]
// Product stage, pen registers and quad emitter that walks the six vertices.
// Depends on gqvg_pkg for lookup_t, cfg_t and saturation helpers.
`timescale 1ns / 1ps
module gqvg_quad (
  input  logic               clk,
  input  logic               rst_n,
  input  gqvg_pkg::lookup_t  lkp,
  input  gqvg_pkg::cfg_t     cfg,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] vertex_x,
  output logic signed [31:0] vertex_y,
  output logic [16:0]        tex_s,
  output logic [16:0]        tex_t,
  output logic               last_vertex
);
  import gqvg_pkg::*;

  // product stage
  logic               v2_r;
  logic               render_r;
  logic               first_r;
  logic signed [31:0] start_x_r;
  logic signed [31:0] start_y_r;
  logic signed [32:0] lfx_r;
  logic signed [32:0] tpy_r;
  logic [31:0]        wx_r;
  logic [31:0]        hy_r;
  logic [24:0]        su_r;
  logic [24:0]        tv_r;
  logic [37:0]        advp_r;
  logic [15:0]        tex_u_r;
  logic signed [32:0] lf_ext;
  logic signed [32:0] tp_ext;
  logic signed [32:0] sx_ext;
  logic signed [32:0] sy_ext;

  // pen and quad registers
  logic signed [31:0] pen_x_r;
  logic signed [31:0] pen_y_r;
  logic signed [31:0] qx0_r;
  logic signed [31:0] qx1_r;
  logic signed [31:0] qyt_r;
  logic signed [31:0] qyb_r;
  logic [16:0]        qs0_r;
  logic [16:0]        qs1_r;
  logic [16:0]        qt1_r;
  logic [2:0]         cnt_r;
  logic               busy_r;

  logic               emit2;
  logic               s3_free;
  logic               s2_go;
  logic               load_quad;
  logic               last;
  logic signed [31:0] base_x;
  logic signed [31:0] base_y;
  logic signed [39:0] x0_w;
  logic signed [39:0] x1_w;
  logic signed [39:0] yt_w;
  logic signed [39:0] yb_w;
  logic signed [39:0] pen_sum;
  logic [25:0]        s1_w;
  logic               use_x1;
  logic               use_yb;

  assign last      = cnt_r == LAST_VERTEX_IDX;
  assign emit2     = render_r & (wx_r != '0) & (hy_r != '0);
  assign s3_free   = !busy_r | (out_ready & last);
  assign s2_go     = v2_r & (!emit2 | s3_free);
  assign load_quad = s2_go & emit2;
  assign take      = lkp.valid & (!v2_r | s2_go);

  assign lf_ext = 33'(lkp.entry.lf);
  assign tp_ext = 33'(lkp.entry.tp);
  assign sx_ext = {9'd0, cfg.scale_x};
  assign sy_ext = {9'd0, cfg.scale_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (take) begin
      v2_r <= 1'b1;
    end else if (s2_go) begin
      v2_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      render_r  <= lkp.render;
      first_r   <= lkp.first;
      start_x_r <= lkp.start_x;
      start_y_r <= lkp.start_y;
      lfx_r     <= lf_ext * sx_ext;
      tpy_r     <= tp_ext * sy_ext;
      wx_r      <= 32'(lkp.entry.wd) * 32'(cfg.scale_x);
      hy_r      <= 32'(lkp.entry.rw) * 32'(cfg.scale_y);
      su_r      <= 25'(lkp.entry.wd) * 25'(cfg.inv_atlas_width);
      tv_r      <= 25'(lkp.entry.rw) * 25'(cfg.inv_atlas_height);
      advp_r    <= 38'(lkp.entry.adv) * 38'(cfg.advance_scale);
      tex_u_r   <= lkp.entry.tex_u;
    end
  end

  // a string start overrides the pen before this glyph is placed
  assign base_x  = first_r ? start_x_r : pen_x_r;
  assign base_y  = first_r ? start_y_r : pen_y_r;
  assign x0_w    = 40'(base_x) + 40'(lfx_r);
  assign x1_w    = x0_w + $signed({8'd0, wx_r});
  assign yt_w    = 40'(base_y) + 40'(tpy_r);
  assign yb_w    = yt_w - $signed({8'd0, hy_r});
  assign pen_sum = 40'(base_x) + $signed({2'b00, advp_r});
  assign s1_w    = 26'(tex_u_r) + 26'(su_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
    end else if (s2_go && render_r) begin
      pen_x_r <= sat32(pen_sum);
      pen_y_r <= base_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (load_quad) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r && out_ready) begin
      if (last) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_quad) begin
      qx0_r <= sat32(x0_w);
      qx1_r <= sat32(x1_w);
      qyt_r <= sat32(yt_w);
      qyb_r <= sat32(yb_w);
      qs0_r <= {1'b0, tex_u_r};
      qs1_r <= sat_tex(s1_w);
      qt1_r <= sat_tex(26'(tv_r));
    end
  end

  // vertex order: left-top, right-top, left-bottom, right-top, left-bottom, right-bottom
  always_comb begin
    case (cnt_r) inside
      3'd1, 3'd3, 3'd5: use_x1 = 1'b1;
      default:          use_x1 = 1'b0;
    endcase
    case (cnt_r) inside
      3'd2, 3'd4, 3'd5: use_yb = 1'b1;
      default:          use_yb = 1'b0;
    endcase
  end

  assign out_valid   = busy_r;
  assign vertex_x    = use_x1 ? qx1_r : qx0_r;
  assign vertex_y    = use_yb ? qyb_r : qyt_r;
  assign tex_s       = use_x1 ? qs1_r : qs0_r;
  assign tex_t       = use_yb ? qt1_r : '0;
  assign last_vertex = last;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r <= LAST_VERTEX_IDX)
    else $error("vertex counter past the sixth vertex");

  a_quad_start: assert property (@(posedge clk) disable iff (!rst_n)
    load_quad |=> busy_r && cnt_r == 3'd0)
    else $error("new quad did not start at its first vertex");

  a_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !out_ready && !load_quad) |=> busy_r && $stable(cnt_r) && $stable(qx0_r))
    else $error("stalled quad changed without a taken vertex");

endmodule

[rtl/glyph_quad_vertex_generator_top.sv]
// Top level of the glyph quad vertex generator: config registers, glyph table, quad emitter.
// Depends on gqvg_pkg, gqvg_in_if, gqvg_out_if, gqvg_cfg, gqvg_table, gqvg_quad.
//
//   channel | direction | handshake             | carries
//   in_ch   | in        | valid/ready           | glyph load or character render request
//   out_ch  | out       | valid/ready           | one vertex, six per drawn glyph
//   cfg     | in        | APB psel/penable      | scales and reciprocal atlas sizes
//
// A drawn glyph holds the result channel for its six vertices, and the next glyph's
// quad loads as the last of them is taken.
// The first vertex of a render request passes the table RAM read, the product
// stage, then the quad register. Empty glyphs only move the pen.
// Reset clears the pen and one valid flag per table entry, and loads the config defaults.
// A stalled output holds its vertex; requests keep flowing until the lookup and
// product stages are both full.
`timescale 1ns / 1ps
module glyph_quad_vertex_generator_top #(
  parameter int GLYPH_COUNT = gqvg_pkg::GLYPH_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  gqvg_in_if.sink                     in_ch,
  gqvg_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gqvg_pkg::CFG_AW-1:0] paddr,
  input  logic [gqvg_pkg::CFG_DW-1:0] pwdata,
  output logic [gqvg_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import gqvg_pkg::*;

  cfg_t    cfg;
  lookup_t lkp;
  entry_t  load_entry;
  logic    take;
  logic    in_ready;

  assign load_entry.adv   = in_ch.load_advance;
  assign load_entry.wd    = in_ch.load_width;
  assign load_entry.rw    = in_ch.load_rows;
  assign load_entry.lf    = in_ch.load_left;
  assign load_entry.tp    = in_ch.load_top;
  assign load_entry.tex_u = in_ch.load_tex_u;
  assign in_ch.ready      = in_ready;

  gqvg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gqvg_table #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_table (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ready),
    .opcode          (in_ch.opcode),
    .first_of_string (in_ch.first_of_string),
    .start_x         (in_ch.start_x),
    .start_y         (in_ch.start_y),
    .char_code       (in_ch.char_code),
    .load_entry      (load_entry),
    .take            (take),
    .lkp             (lkp)
  );

  gqvg_quad u_quad (
    .clk         (clk),
    .rst_n       (rst_n),
    .lkp         (lkp),
    .cfg         (cfg),
    .take        (take),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .vertex_x    (out_ch.vertex_x),
    .vertex_y    (out_ch.vertex_y),
    .tex_s       (out_ch.tex_s),
    .tex_t       (out_ch.tex_t),
    .last_vertex (out_ch.last_vertex)
  );

endmodule
